>>> rtl/core/cof_pkg.sv
`default_nettype none

package cof_pkg;

  localparam logic [15:0] HIGH_PAGE = 16'hFF00;
  localparam int unsigned BYTE_BITS = 8;

  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 88;

  // addressing modes
  localparam logic [4:0] M_IMP    = 5'd0;
  localparam logic [4:0] M_R      = 5'd1;
  localparam logic [4:0] M_R_R    = 5'd2;
  localparam logic [4:0] M_R_D8   = 5'd3;
  localparam logic [4:0] M_R_D16  = 5'd4;
  localparam logic [4:0] M_D16    = 5'd5;
  localparam logic [4:0] M_MR_R   = 5'd6;
  localparam logic [4:0] M_R_MR   = 5'd7;
  localparam logic [4:0] M_R_HLI  = 5'd8;
  localparam logic [4:0] M_R_HLD  = 5'd9;
  localparam logic [4:0] M_HLI_R  = 5'd10;
  localparam logic [4:0] M_HLD_R  = 5'd11;
  localparam logic [4:0] M_R_A8   = 5'd12;
  localparam logic [4:0] M_A8_R   = 5'd13;
  localparam logic [4:0] M_HL_SPR = 5'd14;
  localparam logic [4:0] M_D8     = 5'd15;
  localparam logic [4:0] M_A16_R  = 5'd16;
  localparam logic [4:0] M_D16_R  = 5'd17;
  localparam logic [4:0] M_MR_D8  = 5'd18;
  localparam logic [4:0] M_MR     = 5'd19;
  localparam logic [4:0] M_R_A16  = 5'd20;

  // word operation
  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_REQ  = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_ONE  = 4'b0010,
    PH_TWO  = 4'b0100,
    PH_THREE = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] address;
    logic [15:0] operand;
    logic [15:0] dest_addr;
    logic        to_mem;
    logic [15:0] new_pc;
    logic [15:0] new_hl;
    logic        hl_written;
    logic [1:0]  bus_cycles;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/cpu_operand_fetch.sv
`default_nettype none

// channel  dir  tdata                                          tuser
// s_axis   in   has_instruction, mode, reg1_value, reg1_is_c,  operation
//               reg2_value, pc_value, hl_value, read_data
// m_axis   out  address, operand, dest_addr, to_mem,           kind
//               new_pc, new_hl, hl_written, bus_cycles
//
// one word per cycle while m_axis does not stall; a word is held in the input
// register, then its result lands in the output register
// bus read latency outside the block sets the pace of a whole fetch
// rst clears phase, saved operands and the valid flags of both registers
// a stalled m_axis holds the output register, and s_axis takes a new word
// when the input register is empty or moves on in the same cycle

module cpu_operand_fetch (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // has_instruction, mode, reg1_value, reg1_is_c, reg2_value, pc_value,
  // hl_value, read_data
  input  wire logic [cof_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // operation
  input  wire logic                             s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // address, operand, dest_addr, to_mem, new_pc, new_hl,
  // hl_written, bus_cycles
  output logic [cof_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
  // kind
  output logic [1:0]                            m_axis_tuser
);

  logic        in_valid;
  logic        in_op;
  logic        in_has;
  logic [4:0]  in_mode;
  logic [15:0] in_reg1;
  logic        in_c;
  logic [15:0] in_reg2;
  logic [15:0] in_pc;
  logic [15:0] in_hl;
  logic [7:0]  in_rd;

  logic             out_valid;
  cof_pkg::result_t out_res;

  cof_pkg::phase_t phase, phase_next;
  logic [4:0]  pending_mode, pending_mode_next;
  logic [7:0]  low_byte, low_byte_next;
  logic [15:0] saved_pc, saved_pc_next;
  logic [15:0] saved_reg1, saved_reg1_next;
  logic [15:0] saved_reg2, saved_reg2_next;
  logic [15:0] saved_hl, saved_hl_next;
  logic [15:0] last_operand, last_operand_next;

  logic             advance;
  logic             have_res;
  logic             is_done;
  cof_pkg::result_t res;
  cof_pkg::result_t fin;
  logic [15:0]      word;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tready && s_axis_tvalid) begin
      in_op   <= s_axis_tuser;
      in_has  <= s_axis_tdata[0];
      in_mode <= s_axis_tdata[5:1];
      in_reg1 <= s_axis_tdata[21:6];
      in_c    <= s_axis_tdata[22];
      in_reg2 <= s_axis_tdata[38:23];
      in_pc   <= s_axis_tdata[54:39];
      in_hl   <= s_axis_tdata[70:55];
      in_rd   <= s_axis_tdata[78:71];
    end
  end

  assign word = {in_rd, low_byte};

  // completion of a mode whose last byte just came back
  always_comb begin
    fin         = '0;
    fin.kind    = cof_pkg::KIND_DONE;
    fin.operand = {8'd0, in_rd};
    fin.new_pc  = saved_pc;
    fin.new_hl  = saved_hl;
    case (pending_mode)
      cof_pkg::M_R_D8, cof_pkg::M_R_A8, cof_pkg::M_HL_SPR, cof_pkg::M_D8: begin
        fin.new_pc = saved_pc + 16'd1;
      end
      cof_pkg::M_MR_D8: begin
        fin.dest_addr = saved_reg1;
        fin.to_mem    = 1'b1;
        fin.new_pc    = saved_pc + 16'd1;
      end
      cof_pkg::M_A8_R: begin
        fin.operand   = last_operand;
        fin.dest_addr = {8'd0, in_rd} | cof_pkg::HIGH_PAGE;
        fin.to_mem    = 1'b1;
        fin.new_pc    = saved_pc + 16'd1;
      end
      cof_pkg::M_R_D16, cof_pkg::M_D16: begin
        fin.operand = word;
        fin.new_pc  = saved_pc + 16'd2;
      end
      cof_pkg::M_A16_R, cof_pkg::M_D16_R: begin
        fin.operand   = saved_reg2;
        fin.dest_addr = word;
        fin.to_mem    = 1'b1;
        fin.new_pc    = saved_pc + 16'd2;
      end
      cof_pkg::M_R_MR: begin
      end
      cof_pkg::M_R_HLI: begin
        fin.new_hl     = saved_hl + 16'd1;
        fin.hl_written = 1'b1;
      end
      cof_pkg::M_R_HLD: begin
        fin.new_hl     = saved_hl - 16'd1;
        fin.hl_written = 1'b1;
      end
      cof_pkg::M_MR: begin
        fin.dest_addr = saved_reg1;
        fin.to_mem    = 1'b1;
      end
      default: begin
        fin.new_pc = saved_pc + 16'd2;
      end
    endcase
  end

  always_comb begin
    res               = '0;
    have_res          = 1'b0;
    is_done           = 1'b0;
    phase_next        = phase;
    pending_mode_next = pending_mode;
    low_byte_next     = low_byte;
    saved_pc_next     = saved_pc;
    saved_reg1_next   = saved_reg1;
    saved_reg2_next   = saved_reg2;
    saved_hl_next     = saved_hl;
    last_operand_next = last_operand;

    if (in_op == cof_pkg::OP_START) begin
      if (in_has) begin
        have_res = 1'b1;
        if (in_mode > cof_pkg::M_R_A16) begin
          res.kind    = cof_pkg::KIND_ERR;
          res.operand = last_operand;
          res.new_pc  = in_pc;
          res.new_hl  = in_hl;
        end else begin
          phase_next        = cof_pkg::PH_IDLE;
          pending_mode_next = in_mode;
          saved_pc_next     = in_pc;
          saved_reg1_next   = in_reg1;
          saved_reg2_next   = in_reg2;
          saved_hl_next     = in_hl;
          res.new_pc        = in_pc;
          res.new_hl        = in_hl;
          case (in_mode)
            cof_pkg::M_IMP: begin
              is_done     = 1'b1;
              res.operand = last_operand;
            end
            cof_pkg::M_R: begin
              is_done     = 1'b1;
              res.operand = in_reg1;
            end
            cof_pkg::M_R_R: begin
              is_done     = 1'b1;
              res.operand = in_reg2;
            end
            cof_pkg::M_MR_R: begin
              is_done       = 1'b1;
              res.operand   = in_reg2;
              res.dest_addr = in_c ? (in_reg1 | cof_pkg::HIGH_PAGE) : in_reg1;
              res.to_mem    = 1'b1;
            end
            cof_pkg::M_HLI_R: begin
              is_done        = 1'b1;
              res.operand    = in_reg2;
              res.dest_addr  = in_reg1;
              res.to_mem     = 1'b1;
              res.new_hl     = in_hl + 16'd1;
              res.hl_written = 1'b1;
            end
            cof_pkg::M_HLD_R: begin
              is_done        = 1'b1;
              res.operand    = in_reg2;
              res.dest_addr  = in_reg1;
              res.to_mem     = 1'b1;
              res.new_hl     = in_hl - 16'd1;
              res.hl_written = 1'b1;
            end
            cof_pkg::M_R_MR: begin
              phase_next  = cof_pkg::PH_ONE;
              res         = '0;
              res.address = in_c ? (in_reg2 | cof_pkg::HIGH_PAGE) : in_reg2;
            end
            cof_pkg::M_R_HLI, cof_pkg::M_R_HLD: begin
              phase_next  = cof_pkg::PH_ONE;
              res         = '0;
              res.address = in_reg2;
            end
            cof_pkg::M_MR: begin
              phase_next  = cof_pkg::PH_ONE;
              res         = '0;
              res.address = in_reg1;
            end
            default: begin
              phase_next  = cof_pkg::PH_ONE;
              res         = '0;
              res.address = in_pc;
            end
          endcase
          if (is_done) begin
            res.kind          = cof_pkg::KIND_DONE;
            last_operand_next = res.operand;
          end
        end
      end
    end else begin
      case (phase)
        cof_pkg::PH_ONE: begin
          have_res = 1'b1;
          if (pending_mode inside {cof_pkg::M_R_D16, cof_pkg::M_D16, cof_pkg::M_A16_R,
                                   cof_pkg::M_D16_R, cof_pkg::M_R_A16}) begin
            low_byte_next = in_rd;
            phase_next    = cof_pkg::PH_TWO;
            res.address   = saved_pc + 16'd1;
          end else begin
            is_done        = 1'b1;
            res            = fin;
            res.bus_cycles = 2'd1;
          end
        end
        cof_pkg::PH_TWO: begin
          have_res = 1'b1;
          if (pending_mode == cof_pkg::M_R_A16) begin
            phase_next  = cof_pkg::PH_THREE;
            res.address = word;
          end else begin
            is_done        = 1'b1;
            res            = fin;
            res.bus_cycles = 2'd2;
          end
        end
        cof_pkg::PH_THREE: begin
          have_res       = 1'b1;
          is_done        = 1'b1;
          res            = fin;
          res.bus_cycles = 2'd3;
        end
        default: begin
        end
      endcase
      if (is_done) begin
        phase_next        = cof_pkg::PH_IDLE;
        last_operand_next = res.operand;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      phase        <= cof_pkg::PH_IDLE;
      pending_mode <= '0;
      low_byte     <= '0;
      saved_pc     <= '0;
      saved_reg1   <= '0;
      saved_reg2   <= '0;
      saved_hl     <= '0;
      last_operand <= '0;
    end else begin
      if (advance) begin
        out_valid    <= have_res;
        phase        <= phase_next;
        pending_mode <= pending_mode_next;
        low_byte     <= low_byte_next;
        saved_pc     <= saved_pc_next;
        saved_reg1   <= saved_reg1_next;
        saved_reg2   <= saved_reg2_next;
        saved_hl     <= saved_hl_next;
        last_operand <= last_operand_next;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.kind;
  assign m_axis_tdata  = {4'd0, out_res.bus_cycles, out_res.hl_written, out_res.new_hl,
                          out_res.new_pc, out_res.to_mem, out_res.dest_addr,
                          out_res.operand, out_res.address};

endmodule

`default_nettype wire

>>> sim/tb_cpu_operand_fetch.sv
`timescale 1ns / 100ps

module tb_cpu_operand_fetch;

  localparam logic [4:0] MODE_UNKNOWN_LO  = 5'd21;
  localparam logic [4:0] MODE_UNKNOWN_MID = 5'd25;
  localparam logic [4:0] MODE_UNKNOWN_HI  = 5'd31;

  // input word, highest field first so that has_instr lands in bit 0
  typedef struct packed {
    logic [7:0]  read_data;
    logic [15:0] hl;
    logic [15:0] pc;
    logic [15:0] reg2;
    logic        reg1_is_c;
    logic [15:0] reg1;
    logic [4:0]  mode;
    logic        has_instr;
  } fetch_word_t;

  typedef struct packed {
    logic [3:0]  pad;
    logic [1:0]  bus_cycles;
    logic        hl_written;
    logic [15:0] new_hl;
    logic [15:0] new_pc;
    logic        to_mem;
    logic [15:0] dest_addr;
    logic [15:0] operand;
    logic [15:0] address;
  } out_word_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [cof_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                           s_axis_tuser = cof_pkg::OP_START;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b1;
  logic [cof_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0]                     m_axis_tuser;

  cpu_operand_fetch dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk = ~clk;

  // predictor state
  cof_pkg::phase_t ph = cof_pkg::PH_IDLE;
  logic [4:0]  pend_mode = '0;
  logic [7:0]  low_b = '0;
  logic [15:0] pc_at_start = '0;
  logic [15:0] reg1_at_start = '0;
  logic [15:0] reg2_at_start = '0;
  logic [15:0] hl_at_start = '0;
  logic [15:0] prev_fetch = '0;

  cof_pkg::result_t fetch_results[$];
  int      results_due = 0;
  int      results_checked = 0;
  int      words_sent = 0;
  int      errors = 0;
  bit      idle_on = 1'b1;
  int      stall_left = 0;

  function automatic cof_pkg::result_t bus_request(input logic [15:0] addr);
    cof_pkg::result_t r;
    r = '0;
    r.kind = cof_pkg::KIND_REQ;
    r.address = addr;
    return r;
  endfunction

  function automatic cof_pkg::result_t fetch_done(input logic [15:0] fd, md, input logic dm,
                                                  input logic [15:0] pc, hl, input logic hw,
                                                  input logic [1:0] cyc);
    cof_pkg::result_t r;
    r = '0;
    r.kind = cof_pkg::KIND_DONE;
    r.operand = fd;
    r.dest_addr = md;
    r.to_mem = dm;
    r.new_pc = pc;
    r.new_hl = hl;
    r.hl_written = hw;
    r.bus_cycles = cyc;
    prev_fetch = fd;
    ph = cof_pkg::PH_IDLE;
    return r;
  endfunction

  // last byte of a memory mode has arrived
  function automatic cof_pkg::result_t finish_fetch(input logic [7:0] b,
                                                    input logic [1:0] cyc);
    logic [15:0] word;
    word = {b, low_b};
    case (pend_mode)
      cof_pkg::M_R_D8, cof_pkg::M_R_A8, cof_pkg::M_HL_SPR, cof_pkg::M_D8:
        return fetch_done({8'd0, b}, '0, 1'b0, pc_at_start + 16'd1, hl_at_start, 1'b0, cyc);
      cof_pkg::M_MR_D8:
        return fetch_done({8'd0, b}, reg1_at_start, 1'b1, pc_at_start + 16'd1, hl_at_start,
                          1'b0, cyc);
      cof_pkg::M_A8_R:
        return fetch_done(prev_fetch, cof_pkg::HIGH_PAGE | {8'd0, b}, 1'b1,
                          pc_at_start + 16'd1, hl_at_start, 1'b0, cyc);
      cof_pkg::M_R_D16, cof_pkg::M_D16:
        return fetch_done(word, '0, 1'b0, pc_at_start + 16'd2, hl_at_start, 1'b0, cyc);
      cof_pkg::M_A16_R, cof_pkg::M_D16_R:
        return fetch_done(reg2_at_start, word, 1'b1, pc_at_start + 16'd2, hl_at_start, 1'b0,
                          cyc);
      cof_pkg::M_R_MR:
        return fetch_done({8'd0, b}, '0, 1'b0, pc_at_start, hl_at_start, 1'b0, cyc);
      cof_pkg::M_R_HLI:
        return fetch_done({8'd0, b}, '0, 1'b0, pc_at_start, hl_at_start + 16'd1, 1'b1, cyc);
      cof_pkg::M_R_HLD:
        return fetch_done({8'd0, b}, '0, 1'b0, pc_at_start, hl_at_start - 16'd1, 1'b1, cyc);
      cof_pkg::M_MR:
        return fetch_done({8'd0, b}, reg1_at_start, 1'b1, pc_at_start, hl_at_start, 1'b0,
                          cyc);
      default:
        return fetch_done({8'd0, b}, '0, 1'b0, pc_at_start + 16'd2, hl_at_start, 1'b0, cyc);
    endcase
  endfunction

  function automatic bit fetch_step(input logic op, input fetch_word_t w,
                                    output cof_pkg::result_t r);
    bit wide;
    r = '0;
    if (op == cof_pkg::OP_START) begin
      if (!w.has_instr) return 1'b0;
      if (w.mode > cof_pkg::M_R_A16) begin
        r.kind = cof_pkg::KIND_ERR;
        r.operand = prev_fetch;
        r.new_pc = w.pc;
        r.new_hl = w.hl;
        return 1'b1;
      end
      ph = cof_pkg::PH_IDLE;
      pend_mode = w.mode;
      pc_at_start = w.pc;
      reg1_at_start = w.reg1;
      reg2_at_start = w.reg2;
      hl_at_start = w.hl;
      case (w.mode)
        cof_pkg::M_IMP:
          r = fetch_done(prev_fetch, '0, 1'b0, w.pc, w.hl, 1'b0, 2'd0);
        cof_pkg::M_R:
          r = fetch_done(w.reg1, '0, 1'b0, w.pc, w.hl, 1'b0, 2'd0);
        cof_pkg::M_R_R:
          r = fetch_done(w.reg2, '0, 1'b0, w.pc, w.hl, 1'b0, 2'd0);
        cof_pkg::M_MR_R:
          r = fetch_done(w.reg2, w.reg1_is_c ? (w.reg1 | cof_pkg::HIGH_PAGE) : w.reg1, 1'b1,
                         w.pc, w.hl, 1'b0, 2'd0);
        cof_pkg::M_HLI_R:
          r = fetch_done(w.reg2, w.reg1, 1'b1, w.pc, w.hl + 16'd1, 1'b1, 2'd0);
        cof_pkg::M_HLD_R:
          r = fetch_done(w.reg2, w.reg1, 1'b1, w.pc, w.hl - 16'd1, 1'b1, 2'd0);
        cof_pkg::M_R_MR: begin
          ph = cof_pkg::PH_ONE;
          r = bus_request(w.reg1_is_c ? (w.reg2 | cof_pkg::HIGH_PAGE) : w.reg2);
        end
        cof_pkg::M_R_HLI, cof_pkg::M_R_HLD: begin
          ph = cof_pkg::PH_ONE;
          r = bus_request(w.reg2);
        end
        cof_pkg::M_MR: begin
          ph = cof_pkg::PH_ONE;
          r = bus_request(w.reg1);
        end
        default: begin
          ph = cof_pkg::PH_ONE;
          r = bus_request(w.pc);
        end
      endcase
      return 1'b1;
    end
    wide = pend_mode inside {cof_pkg::M_R_D16, cof_pkg::M_D16, cof_pkg::M_A16_R,
                             cof_pkg::M_D16_R, cof_pkg::M_R_A16};
    case (ph)
      cof_pkg::PH_ONE: begin
        if (wide) begin
          low_b = w.read_data;
          ph = cof_pkg::PH_TWO;
          r = bus_request(pc_at_start + 16'd1);
        end else begin
          r = finish_fetch(w.read_data, 2'd1);
        end
        return 1'b1;
      end
      cof_pkg::PH_TWO: begin
        if (pend_mode == cof_pkg::M_R_A16) begin
          ph = cof_pkg::PH_THREE;
          r = bus_request({w.read_data, low_b});
        end else begin
          r = finish_fetch(w.read_data, 2'd2);
        end
        return 1'b1;
      end
      cof_pkg::PH_THREE: begin
        r = finish_fetch(w.read_data, 2'd3);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic int bytes_needed(input logic [4:0] mode);
    case (mode)
      cof_pkg::M_IMP, cof_pkg::M_R, cof_pkg::M_R_R, cof_pkg::M_MR_R, cof_pkg::M_HLI_R,
      cof_pkg::M_HLD_R:
        return 0;
      cof_pkg::M_R_D16, cof_pkg::M_D16, cof_pkg::M_A16_R, cof_pkg::M_D16_R:
        return 2;
      cof_pkg::M_R_A16:
        return 3;
      default:
        return 1;
    endcase
  endfunction

  function automatic fetch_word_t random_word();
    fetch_word_t w;
    w.has_instr = 1'($urandom);
    w.mode = 5'($urandom);
    w.reg1 = 16'($urandom);
    w.reg1_is_c = 1'($urandom);
    w.reg2 = 16'($urandom);
    w.pc = 16'($urandom);
    w.hl = 16'($urandom);
    w.read_data = 8'($urandom);
    return w;
  endfunction

  function automatic fetch_word_t start_word(input logic [4:0] mode,
                                             input logic [15:0] reg1, reg2, pc, hl,
                                             input logic c);
    fetch_word_t w;
    w = random_word();
    w.has_instr = 1'b1;
    w.mode = mode;
    w.reg1 = reg1;
    w.reg2 = reg2;
    w.pc = pc;
    w.hl = hl;
    w.reg1_is_c = c;
    return w;
  endfunction

  function automatic fetch_word_t data_word(input logic [7:0] b);
    fetch_word_t w;
    w = random_word();
    w.read_data = b;
    return w;
  endfunction

  task automatic send_word(input logic op, input fetch_word_t w);
    cof_pkg::result_t r;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, w};
    s_axis_tuser <= op;
    do @(posedge clk); while (!s_axis_tready);
    words_sent++;
    if (fetch_step(op, w, r)) begin
      fetch_results.push_back(r);
      results_due++;
    end
  endtask

  task automatic run_fetch(input logic [4:0] mode, input int nbytes);
    fetch_word_t w;
    w = random_word();
    w.has_instr = 1'b1;
    w.mode = mode;
    send_word(cof_pkg::OP_START, w);
    repeat (nbytes) send_word(cof_pkg::OP_DATA, random_word());
  endtask

  // results pass the input and output registers of the block, some slack on top
  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    while (fetch_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic test_special_cases();
    fetch_word_t w;
    send_word(cof_pkg::OP_DATA, data_word(8'hFF));
    w = start_word(cof_pkg::M_R, '1, '1, '1, '1, 1'b1);
    w.has_instr = 1'b0;
    send_word(cof_pkg::OP_START, w);
    send_word(cof_pkg::OP_START, start_word(MODE_UNKNOWN_HI, '1, '1, '1, '1, 1'b1));
    send_word(cof_pkg::OP_START, start_word(MODE_UNKNOWN_LO, '0, '0, '0, '0, 1'b0));
    // high page on C
    send_word(cof_pkg::OP_START, start_word(cof_pkg::M_MR_R, 16'h0012, 16'h00AB, 16'h1000,
                                            16'h2000, 1'b1));
    send_word(cof_pkg::OP_START, start_word(cof_pkg::M_R_MR, '1, 16'h0034, '0, '0, 1'b1));
    send_word(cof_pkg::OP_DATA, data_word(8'hFF));
    // hl and pc wrapping
    send_word(cof_pkg::OP_START, start_word(cof_pkg::M_HLD_R, 16'hC000, '1, '0, '0, 1'b0));
    send_word(cof_pkg::OP_START, start_word(cof_pkg::M_R_HLI, '0, 16'h8000, '0, '1, 1'b0));
    send_word(cof_pkg::OP_DATA, data_word(8'h00));
    send_word(cof_pkg::OP_START, start_word(cof_pkg::M_R_D16, '0, '0, '1, '0, 1'b0));
    send_word(cof_pkg::OP_DATA, data_word(8'hFF));
    send_word(cof_pkg::OP_DATA, data_word(8'hFF));
    // new start abandons a fetch, then a stray byte
    send_word(cof_pkg::OP_START, start_word(cof_pkg::M_R_A16, '1, '1, 16'h4000, '1, 1'b0));
    send_word(cof_pkg::OP_DATA, data_word(8'h00));
    send_word(cof_pkg::OP_START, start_word(cof_pkg::M_IMP, '1, '1, '1, '1, 1'b1));
    send_word(cof_pkg::OP_DATA, data_word(8'hFF));
    // unknown mode mid-fetch leaves it running
    send_word(cof_pkg::OP_START, start_word(cof_pkg::M_D16, '0, '0, 16'h0100, '0, 1'b0));
    send_word(cof_pkg::OP_DATA, data_word(8'h11));
    send_word(cof_pkg::OP_START, start_word(MODE_UNKNOWN_MID, '1, '1, '1, '1, 1'b1));
    send_word(cof_pkg::OP_DATA, data_word(8'h22));
    send_word(cof_pkg::OP_START, start_word(cof_pkg::M_A8_R, '1, '1, 16'hFFFF, '0, 1'b0));
    send_word(cof_pkg::OP_DATA, data_word(8'h80));
  endtask

  task automatic test_random_fetches();
    int goal;
    int pick;
    logic [4:0] m;
    fetch_word_t w;
    goal = words_sent + 660;
    while (words_sent < goal) begin
      pick = $urandom_range(0, 19);
      m = 5'($urandom_range(cof_pkg::M_IMP, cof_pkg::M_R_A16));
      if (pick == 0) begin
        send_word(1'($urandom), random_word());
      end else if (pick == 1) begin
        w = random_word();
        w.has_instr = 1'b1;
        w.mode = 5'($urandom_range(MODE_UNKNOWN_LO, MODE_UNKNOWN_HI));
        send_word(cof_pkg::OP_START, w);
      end else if (pick == 2) begin
        run_fetch(m, $urandom_range(0, bytes_needed(m)));
      end else begin
        run_fetch(m, bytes_needed(m));
      end
    end
  endtask

  task automatic test_sender_pause();
    logic [4:0] m;
    repeat (10) begin
      m = 5'($urandom_range(cof_pkg::M_IMP, cof_pkg::M_R_A16));
      run_fetch(m, bytes_needed(m));
      wait_all_results();
    end
  endtask

  task automatic test_steady_stream();
    logic [4:0] m;
    idle_on = 1'b0;
    repeat (120) begin
      m = 5'($urandom_range(cof_pkg::M_IMP, cof_pkg::M_R_A16));
      run_fetch(m, bytes_needed(m));
    end
  endtask

  // receiver stalls
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= (stall_left == 1);
    end else if (!rst && idle_on && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(1, 11);
      m_axis_tready <= 1'b0;
    end
  end

  task automatic check_field(input string name, input logic [15:0] want, got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_results
    out_word_t        got;
    cof_pkg::result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = out_word_t'(m_axis_tdata);
      if (fetch_results.size() == 0) begin
        $error("unexpected word: kind %0d tdata %h", m_axis_tuser, m_axis_tdata);
        errors++;
      end else begin
        want = fetch_results.pop_front();
        check_field("kind", 16'(want.kind), 16'(m_axis_tuser));
        check_field("address", want.address, got.address);
        check_field("operand", want.operand, got.operand);
        check_field("dest_addr", want.dest_addr, got.dest_addr);
        check_field("to_mem", 16'(want.to_mem), 16'(got.to_mem));
        check_field("new_pc", want.new_pc, got.new_pc);
        check_field("new_hl", want.new_hl, got.new_hl);
        check_field("hl_written", 16'(want.hl_written), 16'(got.hl_written));
        check_field("bus_cycles", 16'(want.bus_cycles), 16'(got.bus_cycles));
        results_checked++;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_special_cases();
    test_random_fetches();
    test_sender_pause();
    test_steady_stream();
    wait_all_results();
    $display("sent %0d words, expected %0d results, checked %0d", words_sent, results_due,
             results_checked);
    $display("all 21 modes, unknown modes, aborted fetches and stray bytes, with stalls");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/cof_pkg.sv
rtl/core/cpu_operand_fetch.sv
sim/tb_cpu_operand_fetch.sv
